>>> hdl/jfe_pkg.sv
package jfe_pkg;

    localparam logic [7:0] MarkLead = 8'hff;
    localparam logic [7:0] MarkSoi  = 8'hd8;
    localparam logic [7:0] MarkEoi  = 8'hd9;

    localparam int HistLen = 7;

    // queue depth, power of two so the pointers wrap on their own
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic {
        K_DATA,
        K_START
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last_byte;
        logic [7:0]  place;
        logic [7:0]  pack;
        logic [15:0] size;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qctl;

endpackage

>>> hdl/jfe_front.sv
module jfe_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_in_byte,
    input  logic         i_q_full,
    output logic         o_push,
    output jfe_pkg::t_cmd o_cmd
);
    import jfe_pkg::*;

    logic [7:0]  r_hist [HistLen];
    logic        r_in_frame;
    logic        n_in_frame;
    logic [7:0]  r_place;
    logic [7:0]  r_pack;
    logic [15:0] r_size;
    logic        accept;
    logic        after_lead;
    logic        is_start;
    logic        is_end;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign after_lead = (r_hist[0] == MarkLead);
    assign is_start   = !r_in_frame && after_lead && (i_in_byte == MarkSoi);
    assign is_end     = r_in_frame && after_lead && (i_in_byte == MarkEoi);
    assign o_push     = accept && (is_start || r_in_frame);

    always_comb begin
        n_in_frame = r_in_frame;
        if (accept) begin
            if (is_start) begin
                n_in_frame = 1'b1;
            end else if (is_end) begin
                n_in_frame = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.data      = i_in_byte;
        o_cmd.last_byte = is_end;
        if (is_start) begin
            o_cmd.kind  = K_START;
            o_cmd.place = r_hist[6];
            o_cmd.pack  = r_hist[5];
            o_cmd.size  = {r_hist[2], r_hist[1]};
        end else begin
            o_cmd.kind  = K_DATA;
            o_cmd.place = r_place;
            o_cmd.pack  = r_pack;
            o_cmd.size  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            for (int i = 0; i < HistLen; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_in_frame <= n_in_frame;
            if (accept) begin
                r_hist[0] <= i_in_byte;
                for (int i = 1; i < HistLen; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place <= '0;
            r_pack  <= '0;
            r_size  <= '0;
        end else if (accept && is_start) begin
            r_place <= r_hist[6];
            r_pack  <= r_hist[5];
            r_size  <= {r_hist[2], r_hist[1]};
        end
    end

    a_start_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_start) |=> r_in_frame)
        else $error("start marker did not open a frame");
    a_end_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end) |=> !r_in_frame)
        else $error("end marker did not close the frame");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into full queue");

endmodule

>>> hdl/jfe_queue.sv
module jfe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jfe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output jfe_pkg::t_cmd o_head,
    output jfe_pkg::t_qctl o_ctl
);
    import jfe_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (r_count == QCntW'(QDepth));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        o_ctl       = '0;
        o_ctl.push  = do_push;
        o_ctl.pop   = do_pop;
        o_ctl.full  = full;
        o_ctl.empty = empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QDepth))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QPtrW-1:0])
        else $error("queue pointers disagree with count");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !empty) |=> (r_count != QCntW'(QDepth)) || $past(i_push))
        else $error("pop did not free an entry");

endmodule

>>> hdl/jfe_back.sv
module jfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jfe_pkg::t_cmd  i_head,
    input  jfe_pkg::t_qctl i_ctl,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_frame_start,
    output logic           o_frame_end,
    output logic [7:0]     o_place_number,
    output logic [7:0]     o_pack_number,
    output logic [15:0]    o_image_size,
    output logic           o_run_last
);
    import jfe_pkg::*;

    logic        r_valid;
    logic        r_phase;
    logic        n_phase;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_end;
    logic [7:0]  r_place;
    logic [7:0]  r_pack;
    logic [15:0] r_size;
    logic        r_last;
    logic        load;
    logic        n_byte_start;
    logic [7:0]  n_byte;
    logic        n_last;

    assign load = !i_ctl.empty && (!r_valid || !i_out_stall);

    // a start beat expands to lead byte then marker byte
    always_comb begin
        n_phase      = r_phase;
        n_byte       = i_head.data;
        n_byte_start = 1'b0;
        n_last       = 1'b1;
        o_pop        = 1'b0;
        unique case (i_head.kind)
            K_START: begin
                if (!r_phase) begin
                    n_byte       = MarkLead;
                    n_byte_start = 1'b1;
                    n_last       = 1'b0;
                    if (load) begin
                        n_phase = 1'b1;
                    end
                end else begin
                    n_byte = MarkSoi;
                    if (load) begin
                        n_phase = 1'b0;
                        o_pop   = 1'b1;
                    end
                end
            end
            K_DATA: begin
                o_pop = load;
            end
            default: begin
                o_pop = load;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= n_byte;
            r_start <= n_byte_start;
            r_end   <= (i_head.kind == K_DATA) && i_head.last_byte;
            r_place <= i_head.place;
            r_pack  <= i_head.pack;
            r_size  <= i_head.size;
            r_last  <= n_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_byte;
    assign o_frame_start  = r_start;
    assign o_frame_end    = r_end;
    assign o_place_number = r_place;
    assign o_pack_number  = r_pack;
    assign o_image_size   = r_size;
    assign o_run_last     = r_last;

    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_ctl.empty && i_head.kind == K_START))
        else $error("second start beat without start entry");
    a_start_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_start) |-> (!r_last && r_byte == MarkLead && !r_end))
        else $error("malformed frame start beat");
    a_start_then_soi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_phase && i_head.kind == K_START) |=> r_phase)
        else $error("start entry did not advance to marker beat");

endmodule

>>> hdl/jpeg_frame_extractor.sv
// JPEG frame extractor: takes one camera byte per beat and, once an FF D8 start
// marker shows up while searching, emits FF (frame_start) and D8 followed by every
// later byte up to and including the D9 of an FF D9 end marker (frame_end). The
// header carried on every output beat is latched from the seven bytes before the
// D8: place at -7, pack at -6, size high byte at -3 and low byte at -2. An input
// byte is taken every cycle while the four-entry command queue has room; a start
// marker makes two output beats, so the input stalls only when the output side
// stalls or a burst of start markers fills the queue. Bytes seen while searching
// produce no output beats. An input byte is written into the queue, then loaded
// into the output register before it is shown as an output beat.
module jpeg_frame_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic [7:0]  o_place_number,
    output logic [7:0]  o_pack_number,
    output logic [15:0] o_image_size,
    output logic        o_run_last
);
    import jfe_pkg::*;

    t_cmd  push_cmd;
    t_cmd  head_cmd;
    t_qctl qctl;
    logic  push;
    logic  pop;

    jfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_q_full   (qctl.full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    jfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_ctl   (qctl)
    );

    jfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_ctl          (qctl),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_place_number (o_place_number),
        .o_pack_number  (o_pack_number),
        .o_image_size   (o_image_size),
        .o_run_last     (o_run_last)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import jfe_pkg::*;

    localparam int TargetBeats = 800;
    localparam int CycleLimit  = 400000;

    typedef struct packed {
        logic [7:0]  val;
        logic        sof;
        logic        eof;
        logic [7:0]  place;
        logic [7:0]  pack;
        logic [15:0] size;
        logic        last;
    } t_frame_beat;

    class frame_scoreboard;
        t_frame_beat expected_q[$];
        bit          in_frame;
        logic [7:0]  hist[HistLen];
        logic [7:0]  held_place;
        logic [7:0]  held_pack;
        logic [15:0] held_size;
        int          mismatches;

        function new();
            in_frame    = 1'b0;
            foreach (hist[i]) hist[i] = 8'h00;
            held_place  = 8'h00;
            held_pack   = 8'h00;
            held_size   = 16'h0000;
            mismatches  = 0;
        endfunction

        function void push_beat(logic [7:0] v, logic sof, logic eof, logic last);
            t_frame_beat b;
            b.val   = v;
            b.sof   = sof;
            b.eof   = eof;
            b.place = held_place;
            b.pack  = held_pack;
            b.size  = held_size;
            b.last  = last;
            expected_q.push_back(b);
        endfunction

        function void note_byte(logic [7:0] b);
            bit after_ff;
            bit eoi;
            after_ff = (hist[0] == MarkLead);
            if (!in_frame) begin
                if (after_ff && b == MarkSoi) begin
                    held_place = hist[6];
                    held_pack  = hist[5];
                    held_size  = {hist[2], hist[1]};
                    push_beat(MarkLead, 1'b1, 1'b0, 1'b0);
                    push_beat(MarkSoi, 1'b0, 1'b0, 1'b1);
                    in_frame = 1'b1;
                end
            end else begin
                eoi = after_ff && b == MarkEoi;
                push_beat(b, 1'b0, eoi, 1'b1);
                if (eoi) in_frame = 1'b0;
            end
            for (int i = HistLen - 1; i > 0; i--) hist[i] = hist[i - 1];
            hist[0] = b;
        endfunction

        task report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
            mismatches++;
        endtask

        task cmp_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) report_mismatch(what, exp_v, got_v);
        endtask

        task check_beat(t_frame_beat got);
            t_frame_beat exp_b;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", 16'h0, {8'h0, got.val});
            end else begin
                exp_b = expected_q.pop_front();
                cmp_field("out_byte", 16'(exp_b.val), 16'(got.val));
                cmp_field("frame_start", 16'(exp_b.sof), 16'(got.sof));
                cmp_field("frame_end", 16'(exp_b.eof), 16'(got.eof));
                cmp_field("place_number", 16'(exp_b.place), 16'(got.place));
                cmp_field("pack_number", 16'(exp_b.pack), 16'(got.pack));
                cmp_field("image_size", exp_b.size, got.size);
                cmp_field("run_last", 16'(exp_b.last), 16'(got.last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_frame_start;
    logic        o_frame_end;
    logic [7:0]  o_place_number;
    logic [7:0]  o_pack_number;
    logic [15:0] o_image_size;
    logic        o_run_last;

    frame_scoreboard sb = new();
    bit calm = 1'b0;
    int cycles = 0;
    int stall_hold = 0;
    int n_sent = 0;

    logic [7:0] directed_bytes [21] = '{
        MarkLead, MarkSoi,
        8'h00, MarkLead, MarkSoi, MarkLead, MarkEoi,
        MarkEoi, MarkLead, MarkEoi,
        8'ha5, 8'h5a, 8'h00, 8'hff, 8'h80, 8'h01, MarkLead, MarkSoi,
        MarkLead, MarkLead, MarkEoi
    };

    jpeg_frame_extractor uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_place_number (o_place_number),
        .o_pack_number  (o_pack_number),
        .o_image_size   (o_image_size),
        .o_run_last     (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // input side noted before output side
    always @(posedge i_clk) begin
        t_frame_beat got;
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_byte(i_in_byte);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.val   = o_out_byte;
            got.sof   = o_frame_start;
            got.eof   = o_frame_end;
            got.place = o_place_number;
            got.pack  = o_pack_number;
            got.size  = o_image_size;
            got.last  = o_run_last;
            sb.check_beat(got);
        end
    end

    // output backpressure
    always @(posedge i_clk) begin
        int r;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else if (r < 29) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 40);
            end else begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 7);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic send_frame();
        int body_len;
        int r;
        for (int i = 0; i < 6; i++) send_byte(pick_byte());
        send_byte(MarkLead);
        send_byte(MarkSoi);
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
        for (int i = 0; i < body_len; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_byte(MarkLead);
                send_byte(MarkSoi);
            end else if (r == 1) begin
                send_byte(MarkLead);
                send_byte(MarkLead);
            end else begin
                send_byte(pick_byte());
            end
        end
        send_byte(MarkLead);
        send_byte(MarkEoi);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_byte(MarkLead);
                send_byte(MarkEoi);
            end else begin
                send_byte(pick_byte());
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        while (n_sent < TargetBeats) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0) send_noise();
            else send_frame();
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/jfe_pkg.sv
hdl/jfe_front.sv
hdl/jfe_queue.sv
hdl/jfe_back.sv
hdl/jpeg_frame_extractor.sv
tb/tb_top.sv
